// ===== hdl/fpe_pkg.sv =====
// ----------------------------------------------------------------------------
// fpe_pkg: shared types and constants of the filename percent encoder
// Payload structs, job struct between front and back, escape table, helpers.
// ----------------------------------------------------------------------------
package fpe_pkg;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        string_last;
   } req_type;

   typedef struct packed {
      logic [15:0] out_unit;
      logic        run_end;
      logic        string_end;
   } rsp_type;

   // one code unit with its escape decision
   typedef struct packed {
      logic [15:0] unit;
      logic        esc;
   } enc_type;

   // all encodings caused by one input item
   typedef struct packed {
      enc_type first;
      logic    second_valid;
      enc_type second;
      logic    string_end;
   } job_type;

   // escape marks for ascii codes, bit n marks code n
   localparam logic [127:0] ESC_TABLE = {64'h9000000010000000, 64'hD4008425FFFFFFFF};

   localparam logic [15:0] CHAR_PERCENT = 16'h0025;
   localparam logic [15:0] CHAR_PLUS    = 16'h002B;
   localparam logic [15:0] CHAR_ZERO    = 16'h0030;
   localparam logic [15:0] CHAR_UPPER_A = 16'h0041;

   function automatic logic is_lead(input logic [15:0] u);
      return u[15:10] == 6'b110110;
   endfunction

   function automatic logic is_trail(input logic [15:0] u);
      return u[15:10] == 6'b110111;
   endfunction

   function automatic logic must_escape(input logic [15:0] u, input logic [15:0] prev,
                                        input logic [15:0] next);
      logic result;
      if (u[15:7] == 9'd0) begin
         result = ESC_TABLE[u[6:0]];
      end else begin
         result = (is_lead(u) && !is_trail(next)) || (is_trail(u) && !is_lead(prev));
      end
      return result;
   endfunction

   function automatic logic [15:0] hex_digit(input logic [3:0] v);
      logic [15:0] result;
      if (v < 4'd10) begin
         result = CHAR_ZERO + {12'd0, v};
      end else begin
         result = CHAR_UPPER_A + {12'd0, v} - 16'd10;
      end
      return result;
   endfunction

endpackage

// ===== hdl/filename_percent_encoder_top.sv =====
// ----------------------------------------------------------------------------
// filename_percent_encoder_top: filename-safe escaping of a utf-16 stream
// Takes one code unit per transfer and gives the escaped unit stream.
// ----------------------------------------------------------------------------
// usage
//   req side: a queue write port; a unit transfers when req_push is high and
//     req_full is low; string_last marks the final unit of a string
//   rsp side: a queue read port; the oldest result sits on rsp_data while
//     rsp_empty is low and transfers when rsp_pop is high
//   each unit is held until the next one arrives, so the first unit of a
//     string gives nothing until its successor (or string_last) comes in
//   a result passes a queue slot, the job register and the output register
//   throughput: one unit per cycle while units pass unchanged and the receiver
//     keeps up; an escaped unit becomes 3 output units (narrow) or 6 (wide),
//     which the back end emits one per cycle
//   the job queue of QUEUE_DEPTH entries lets the front keep taking units
//     while the back drains; req_full rises once it fills
//   when the receiver stalls, the output register holds and the queue fills
//   reset clears the held unit, the queue and the output register
// ----------------------------------------------------------------------------
module filename_percent_encoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fpe_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fpe_pkg::rsp_type rsp_data
);

   // jobs from front to back
   logic             job_push;
   logic             job_full;
   fpe_pkg::job_type job_in_data;
   logic             job_pop;
   logic             job_empty;
   fpe_pkg::job_type job_out_data;

   // front: holds one unit back and decides escaping with both neighbors
   fpe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_in_data)
   );

   // queue decouples classification from expansion
   fpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   // back: expands escapes into percent sequences
   fpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // front never writes into a full queue
   assert property (@(posedge clock) disable iff (reset) job_push |-> !job_full)
      else $error("job written into full queue");

   // back never takes a job from an empty queue
   assert property (@(posedge clock) disable iff (reset) job_pop |-> !job_empty)
      else $error("job taken from empty queue");

   // no result is offered right after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result offered after reset");

   // a string never ends in the middle of a unit's expansion
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.string_end) |-> rsp_data.run_end)
      else $error("string end without run end");

endmodule

// ===== hdl/fpe_front.sv =====
// ----------------------------------------------------------------------------
// fpe_front: input stage of the filename percent encoder
// Holds one unit back, remembers the prior unit, classifies and queues jobs.
// ----------------------------------------------------------------------------
module fpe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fpe_pkg::req_type req_data,
   output logic             req_full,
   input  logic             job_full,
   output logic             job_push,
   output fpe_pkg::job_type job_data
);

   logic        pending_valid_ff, pending_valid_in;
   logic [15:0] pending_unit_ff, pending_unit_in;
   logic [15:0] prior_unit_ff, prior_unit_in;
   logic        accept;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   always_comb begin
      job_data.string_end = req_data.string_last;
      if (pending_valid_ff) begin
         job_data.first.unit    = pending_unit_ff;
         job_data.first.esc     = fpe_pkg::must_escape(pending_unit_ff, prior_unit_ff,
                                                       req_data.code_unit);
         job_data.second_valid  = req_data.string_last;
         job_data.second.unit   = req_data.code_unit;
         job_data.second.esc    = fpe_pkg::must_escape(req_data.code_unit, pending_unit_ff,
                                                       16'd0);
      end else begin
         job_data.first.unit    = req_data.code_unit;
         job_data.first.esc     = fpe_pkg::must_escape(req_data.code_unit, prior_unit_ff,
                                                       16'd0);
         job_data.second_valid  = 1'b0;
         job_data.second.unit   = req_data.code_unit;
         job_data.second.esc    = 1'b0;
      end
   end

   // first unit of a multi-unit string yields nothing yet
   assign job_push = accept && (pending_valid_ff || req_data.string_last);

   always_comb begin
      pending_valid_in = pending_valid_ff;
      pending_unit_in  = pending_unit_ff;
      prior_unit_in    = prior_unit_ff;
      if (accept) begin
         if (req_data.string_last) begin
            pending_valid_in = 1'b0;
            pending_unit_in  = 16'd0;
            prior_unit_in    = 16'd0;
         end else begin
            if (pending_valid_ff) begin
               prior_unit_in = pending_unit_ff;
            end
            pending_valid_in = 1'b1;
            pending_unit_in  = req_data.code_unit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
         pending_unit_ff  <= 16'd0;
         prior_unit_ff    <= 16'd0;
      end else begin
         pending_valid_ff <= pending_valid_in;
         pending_unit_ff  <= pending_unit_in;
         prior_unit_ff    <= prior_unit_in;
      end
   end

endmodule

// ===== hdl/fpe_queue.sv =====
// ----------------------------------------------------------------------------
// fpe_queue: job queue between front and back
// Small circular buffer of jobs with a fill count.
// ----------------------------------------------------------------------------
module fpe_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fpe_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output fpe_pkg::job_type pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fpe_pkg::job_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/fpe_back.sv =====
// ----------------------------------------------------------------------------
// fpe_back: output stage of the filename percent encoder
// Expands jobs to output units in an output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module fpe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  fpe_pkg::job_type job_data,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fpe_pkg::rsp_type rsp_data
);

   fpe_pkg::job_type cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic             sel_ff, sel_in;
   logic [2:0]       pos_ff, pos_in;
   fpe_pkg::rsp_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   fpe_pkg::enc_type enc;
   logic [2:0]       last_pos;
   logic             last_of_enc, last_of_job, out_ready, advance;
   logic [15:0]      unit_char;

   assign enc       = sel_ff ? cur_ff.second : cur_ff.first;
   assign out_ready = !out_valid_ff || rsp_pop;
   assign advance   = cur_valid_ff && out_ready;

   always_comb begin
      if (!enc.esc) begin
         last_pos = 3'd0;
      end else if (enc.unit[15:8] == 8'd0) begin
         last_pos = 3'd2;
      end else begin
         last_pos = 3'd5;
      end
   end

   assign last_of_enc = pos_ff == last_pos;
   assign last_of_job = last_of_enc && (sel_ff || !cur_ff.second_valid);

   // '%' then two digits, or '%' '+' then four digits
   always_comb begin
      unit_char = enc.unit;
      if (enc.esc) begin
         if (enc.unit[15:8] == 8'd0) begin
            case (pos_ff)
               3'd0:    unit_char = fpe_pkg::CHAR_PERCENT;
               3'd1:    unit_char = fpe_pkg::hex_digit(enc.unit[7:4]);
               default: unit_char = fpe_pkg::hex_digit(enc.unit[3:0]);
            endcase
         end else begin
            case (pos_ff)
               3'd0:    unit_char = fpe_pkg::CHAR_PERCENT;
               3'd1:    unit_char = fpe_pkg::CHAR_PLUS;
               3'd2:    unit_char = fpe_pkg::hex_digit(enc.unit[15:12]);
               3'd3:    unit_char = fpe_pkg::hex_digit(enc.unit[11:8]);
               3'd4:    unit_char = fpe_pkg::hex_digit(enc.unit[7:4]);
               default: unit_char = fpe_pkg::hex_digit(enc.unit[3:0]);
            endcase
         end
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      sel_in       = sel_ff;
      pos_in       = pos_ff;
      job_pop      = 1'b0;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         out_valid_in        = 1'b1;
         out_in.out_unit     = unit_char;
         out_in.run_end      = last_of_job;
         out_in.string_end   = last_of_job && cur_ff.string_end;
         if (last_of_enc) begin
            sel_in = 1'b1;
            pos_in = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
      // load next job when idle or finishing the current one
      if (!cur_valid_ff || (advance && last_of_job)) begin
         job_pop      = !job_empty;
         cur_valid_in = !job_empty;
         cur_in       = job_data;
         sel_in       = 1'b0;
         pos_in       = 3'd0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         pos_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff       <= sel_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
